/* hw/rtl/stbs_pkg.sv */
// ============================================================================
// stbs_pkg: shared types and constants for the sorted table search block
// Field widths, controller state encoding, and controller/datapath structs.
// ============================================================================
package stbs_pkg;

    localparam int CFG_W   = 11;   // entries_in_use register
    localparam int INDEX_W = 10;   // entry_index field
    localparam int DATA_W  = 32;   // entry_value field
    localparam int POS_W   = 10;   // position field

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_STEP,
        ST_HOLD
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic ld_write;    // store entry_value at entry_index
        logic ld_search;   // capture key, open range [0, n-1]
        logic fetch;       // first read at the midpoint
        logic step;        // narrow range, read next midpoint
        logic finish;      // equality check on the last entry read
        logic push;        // move pending result into the output register
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;       // saturated count is zero
        logic converged;   // low == high
        logic out_full;    // output register cannot take a result this cycle
    } t_dp_status;

endpackage

/* hw/rtl/stbs_if.sv */
// ============================================================================
// stbs_if: valid/ready channels for the sorted table search block
// One interface for input beats, one for result beats.
// ============================================================================
interface stbs_in_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic [stbs_pkg::INDEX_W-1:0]        entry_index;
    logic signed [stbs_pkg::DATA_W-1:0]  entry_value;

    modport source (output valid, cmd, entry_index, entry_value, input ready);
    modport sink   (input valid, cmd, entry_index, entry_value, output ready);
endinterface

interface stbs_out_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [stbs_pkg::POS_W-1:0]    position;

    modport source (output valid, found, position, input ready);
    modport sink   (input valid, found, position, output ready);
endinterface

/* hw/rtl/sorted_table_binary_search.sv */
// ============================================================================
// sorted_table_binary_search: leftmost binary search over a signed table
// Write beats fill the table; search beats return found and leftmost position.
// ============================================================================
// Input beats carry cmd, entry_index and entry_value. A write beat (cmd 0)
// stores entry_value at entry_index and gives no result; an index
// at or beyond TABLE_DEPTH is dropped. A search beat (cmd 1) looks for
// entry_value among entries 0..n-1, n being entries_in_use clipped to
// TABLE_DEPTH, and gives exactly one result beat: found, and the leftmost
// matching index in position (0 when not found). The table must hold sorted
// ascending values over that range; nothing checks it, and reading an entry
// never written gives an arbitrary answer. The table is a single-port memory
// with a registered read, and each search step is one read followed by one
// signed compare. A search goes through accept, the first read, one step per
// halving of the range, a final equality check, and the handoff into the
// output register. An empty table answers without a read. The output
// register lets a result wait while the next write or search beat is
// taken; a search that finishes while the previous result is still unclaimed
// waits for it. Write entries_in_use only while the block is idle.
// ============================================================================
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [stbs_pkg::CFG_W-1:0]    i_cfg_wdata,
    stbs_in_if.sink                       i_in,
    stbs_out_if.source                    o_out
);

    stbs_pkg::t_ctrl_cmd  cmd;
    stbs_pkg::t_dp_status status;

    // sequencer: owns in ready and the search walk
    stbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // table memory, range registers, count and result registers
    stbs_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_entry_index (i_in.entry_index),
        .i_entry_value (i_in.entry_value),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_found       (o_out.found),
        .o_position    (o_out.position)
    );

endmodule

/* hw/rtl/stbs_ctrl.sv */
// ============================================================================
// stbs_ctrl: search sequencer
// Accepts beats in idle, walks the binary search, hands off the result.
// ============================================================================
module stbs_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_cmd,
    output logic                   o_in_ready,
    input  stbs_pkg::t_dp_status   i_status,
    output stbs_pkg::t_ctrl_cmd    o_cmd
);

    stbs_pkg::t_state r_state;
    stbs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stbs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            stbs_pkg::ST_IDLE: begin
                if (i_in_valid && (i_in_cmd == stbs_pkg::CMD_SEARCH)) begin
                    n_state = i_status.empty ? stbs_pkg::ST_HOLD : stbs_pkg::ST_FETCH;
                end
            end
            stbs_pkg::ST_FETCH: begin
                n_state = stbs_pkg::ST_STEP;
            end
            stbs_pkg::ST_STEP: begin
                if (i_status.converged) begin
                    n_state = stbs_pkg::ST_HOLD;
                end
            end
            stbs_pkg::ST_HOLD: begin
                if (!i_status.out_full) begin
                    n_state = stbs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stbs_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            stbs_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.ld_write  = i_in_valid && (i_in_cmd == stbs_pkg::CMD_WRITE);
                o_cmd.ld_search = i_in_valid && (i_in_cmd == stbs_pkg::CMD_SEARCH);
            end
            stbs_pkg::ST_FETCH: begin
                o_cmd.fetch = 1'b1;
            end
            stbs_pkg::ST_STEP: begin
                o_cmd.step   = !i_status.converged;
                o_cmd.finish = i_status.converged;
            end
            stbs_pkg::ST_HOLD: begin
                o_cmd.push = !i_status.out_full;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/stbs_dpath.sv */
// ============================================================================
// stbs_dpath: table memory and search datapath
// Holds the table, the search range, the count register and the result.
// ============================================================================
module stbs_dpath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [stbs_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic [stbs_pkg::INDEX_W-1:0]        i_entry_index,
    input  logic signed [stbs_pkg::DATA_W-1:0]  i_entry_value,
    input  stbs_pkg::t_ctrl_cmd                 i_cmd,
    output stbs_pkg::t_dp_status                o_status,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_found,
    output logic [stbs_pkg::POS_W-1:0]          o_position
);

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int WIDE_W = ((CNT_W > stbs_pkg::CFG_W) ? CNT_W : stbs_pkg::CFG_W) + 1;

    logic signed [stbs_pkg::DATA_W-1:0] mem [TABLE_DEPTH];

    logic [stbs_pkg::CFG_W-1:0]         r_cnt;
    logic signed [stbs_pkg::DATA_W-1:0] r_key;
    logic signed [stbs_pkg::DATA_W-1:0] r_rdata;
    logic [IDX_W-1:0]                   r_low;
    logic [IDX_W-1:0]                   r_high;
    logic [IDX_W-1:0]                   r_mid;
    logic                               r_pend_found;
    logic [stbs_pkg::POS_W-1:0]         r_pend_pos;
    logic                               r_out_valid;
    logic                               r_found;
    logic [stbs_pkg::POS_W-1:0]         r_position;

    logic [WIDE_W-1:0] cnt_wide;
    logic [WIDE_W-1:0] depth_wide;
    logic [WIDE_W-1:0] n_sat;
    logic [WIDE_W-1:0] n_last;
    logic              idx_ok;
    logic              key_le;
    logic [IDX_W-1:0]  n_low;
    logic [IDX_W-1:0]  n_high;
    logic [IDX_W:0]    sum_cur;
    logic [IDX_W:0]    sum_next;
    logic [IDX_W-1:0]  mid_cur;
    logic [IDX_W-1:0]  mid_next;
    logic [IDX_W-1:0]  rd_addr;

    // count saturated to depth
    assign cnt_wide   = WIDE_W'(r_cnt);
    assign depth_wide = WIDE_W'(TABLE_DEPTH);
    assign n_sat      = (cnt_wide > depth_wide) ? depth_wide : cnt_wide;
    assign n_last     = n_sat - WIDE_W'(1);
    assign idx_ok     = WIDE_W'(i_entry_index) < depth_wide;

    // one search step: key <= table[mid] keeps the left half
    assign key_le   = r_key <= r_rdata;
    assign n_low    = key_le ? r_low : (r_mid + IDX_W'(1));
    assign n_high   = key_le ? r_mid : r_high;
    assign sum_cur  = {1'b0, r_low} + {1'b0, r_high};
    assign sum_next = {1'b0, n_low} + {1'b0, n_high};
    assign mid_cur  = sum_cur[IDX_W:1];
    assign mid_next = sum_next[IDX_W:1];
    assign rd_addr  = i_cmd.step ? mid_next : mid_cur;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_write && idx_ok) begin
            mem[IDX_W'(i_entry_index)] <= i_entry_value;
        end
        if (i_cmd.fetch || i_cmd.step) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_search) begin
            r_key        <= i_entry_value;
            r_low        <= '0;
            r_high       <= IDX_W'(n_last);
            r_pend_found <= 1'b0;
            r_pend_pos   <= '0;
        end
        if (i_cmd.fetch) begin
            r_mid <= mid_cur;
        end
        if (i_cmd.step) begin
            r_low  <= n_low;
            r_high <= n_high;
            r_mid  <= mid_next;
        end
        if (i_cmd.finish && (r_rdata == r_key)) begin
            r_pend_found <= 1'b1;
            r_pend_pos   <= stbs_pkg::POS_W'(r_low);
        end
        if (i_cmd.push) begin
            r_found    <= r_pend_found;
            r_position <= r_pend_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cnt <= i_cfg_wdata;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.empty     = (n_sat == '0);
    assign o_status.converged = (r_low == r_high);
    assign o_status.out_full  = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_position  = r_position;

endmodule
